// ----- sv/assert_macros.svh -----
// assertion macros shared by the allocator rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define FFHA_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ----- sv/ffha_pkg.sv -----
// types, constants and command codes for the first-fit heap allocator
// no dependencies; used by ffha_dp, ffha_ctrl and the top level
package ffha_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int OFFSET_BITS = 24;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int BYTES_W = 25;
  localparam int ADDR_W  = 32;
  localparam int REQ_W   = 24;
  localparam int ST_W    = 3;
  localparam int OP_W    = 2;
  localparam int LIVE_W  = 7;
  localparam int CALC_W  = OFFSET_BITS + 3;

  localparam int HDR_BYTES   = 24;
  localparam int FTR_BYTES   = 8;
  localparam int OVERHEAD    = HDR_BYTES + FTR_BYTES;
  localparam int ALIGN_BYTES = 8;
  localparam int SPLIT_SLACK = OVERHEAD + ALIGN_BYTES;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOOP      = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_MEM    = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_PTR   = 3'd3;
  localparam logic [ST_W-1:0] ST_DBL_FREE  = 3'd4;
  localparam logic [ST_W-1:0] ST_TBL_FULL  = 3'd5;
  localparam logic [ST_W-1:0] ST_INIT_FAIL = 3'd6;

  typedef logic [4:0] cmd_code_t;

  localparam cmd_code_t C_NOP       = 5'd0;
  localparam cmd_code_t C_ACCEPT    = 5'd1;
  localparam cmd_code_t C_RD        = 5'd2;
  localparam cmd_code_t C_NEXT      = 5'd3;
  localparam cmd_code_t C_HIT       = 5'd4;
  localparam cmd_code_t C_GROW      = 5'd5;
  localparam cmd_code_t C_SHU_INIT  = 5'd6;
  localparam cmd_code_t C_SHU_WR    = 5'd7;
  localparam cmd_code_t C_SPLIT_INS = 5'd8;
  localparam cmd_code_t C_TAKE      = 5'd9;
  localparam cmd_code_t C_FREE_MARK = 5'd10;
  localparam cmd_code_t C_FWD_MERGE = 5'd11;
  localparam cmd_code_t C_SHD_WR    = 5'd12;
  localparam cmd_code_t C_DEC_COUNT = 5'd13;
  localparam cmd_code_t C_SET_PREV  = 5'd14;
  localparam cmd_code_t C_BWD_MERGE = 5'd15;
  localparam cmd_code_t C_INIT      = 5'd16;
  localparam cmd_code_t C_EMIT      = 5'd17;

  typedef struct packed {
    logic                   free;
    logic [OFFSET_BITS-1:0] size;
    logic [OFFSET_BITS-1:0] off;
  } entry_t;

  typedef struct packed {
    cmd_code_t       code;
    logic [ST_W-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            req_zero;
    logic            addr_zero;
    logic            init_ok;
    logic            scan_end;
    logic            hit_alloc;
    logic            hit_free;
    logic            split;
    logic            full;
    logic            grow_fit;
    logic            grow_room;
    logic            tbl_empty;
    logic            idx_gt_pos;
    logic            has_next;
    logic            fwd_ok;
    logic            shd_more;
    logic            pos_zero;
    logic            bwd_ok;
    logic            cur_free;
  } dp_stat_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  region_base;
    logic [BYTES_W-1:0] initial_bytes;
    logic [BYTES_W-1:0] max_bytes;
  } cfg_t;

endpackage

// ----- sv/ffha_dp.sv -----
// datapath: descriptor table memory, counters and heap arithmetic
// depends on ffha_pkg and assert_macros.svh; driven by ffha_ctrl commands
`include "assert_macros.svh"

module ffha_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffha_pkg::cmd_t               cmd,
  input  ffha_pkg::cfg_t               cfg,
  input  logic [ffha_pkg::OP_W-1:0]    in_op,
  input  logic [ffha_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]  in_free_address,
  output ffha_pkg::dp_stat_t           stat,
  output logic [ffha_pkg::ADDR_W-1:0]  out_result_address,
  output logic [ffha_pkg::ST_W-1:0]    out_status,
  output logic [ffha_pkg::LIVE_W-1:0]  out_live_count,
  output logic [ffha_pkg::BYTES_W-1:0] out_held_bytes,
  output logic [ffha_pkg::BYTES_W-1:0] out_heap_bytes
);

  localparam int CW = ffha_pkg::CALC_W;
  localparam int NW = ffha_pkg::CNT_W;
  localparam int BW = ffha_pkg::BYTES_W;
  localparam int AW = ffha_pkg::ADDR_W;
  localparam int OB = ffha_pkg::OFFSET_BITS;

  ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t rd_r;
  ffha_pkg::entry_t cur_r;

  logic [ffha_pkg::OP_W-1:0] op_r;
  logic [BW-1:0]             wanted_r;
  logic [AW-1:0]             tgt_r;
  logic                      addr_zero_r;
  logic [NW-1:0]             idx_r;
  logic [NW-1:0]             pos_r;
  logic [NW-1:0]             count_r;
  logic [BW-1:0]             top_off_r;
  logic [NW-1:0]             live_cnt_r;
  logic [BW-1:0]             held_bytes_r;
  logic [AW-1:0]             res_addr_r;

  logic                      mem_we;
  logic [NW-1:0]             mem_wa;
  ffha_pkg::entry_t          mem_wd;

  logic [CW-1:0] cap, limit, init_round, wanted_c, grow, new_end, cur_sz, cur_end;
  logic [CW-1:0] rd_end, page_mask;
  logic [NW:0]   need;
  logic          split;
  logic [OB-1:0] final_sz;
  logic [BW-1:0] wanted_in;

  // heap arithmetic
  always_comb begin
    page_mask  = ~CW'(ffha_pkg::PAGE_BYTES - 1);
    cap        = CW'(1) << OB;
    limit      = (CW'(cfg.max_bytes) < cap) ? CW'(cfg.max_bytes) : cap;
    init_round = (CW'(cfg.initial_bytes) + CW'(ffha_pkg::PAGE_BYTES - 1)) & page_mask;
    wanted_c   = CW'(wanted_r);
    grow       = (wanted_c + CW'(ffha_pkg::OVERHEAD + ffha_pkg::PAGE_BYTES - 1)) & page_mask;
    new_end    = CW'(top_off_r) + grow;
    cur_sz     = CW'(cur_r.size);
    cur_end    = CW'(cur_r.off) + cur_sz + CW'(ffha_pkg::OVERHEAD);
    rd_end     = CW'(rd_r.off) + CW'(rd_r.size) + CW'(ffha_pkg::OVERHEAD);
    split      = cur_sz >= wanted_c + CW'(ffha_pkg::SPLIT_SLACK);
    final_sz   = split ? wanted_r[OB-1:0] : cur_r.size;
    need       = ((grow - CW'(ffha_pkg::OVERHEAD)) >=
                  (wanted_c + CW'(ffha_pkg::SPLIT_SLACK))) ? (NW+1)'(2) : (NW+1)'(1);
    wanted_in  = (BW'(in_request_bytes) + BW'(ffha_pkg::ALIGN_BYTES - 1)) &
                 ~BW'(ffha_pkg::ALIGN_BYTES - 1);
  end

  always_comb begin
    stat.op         = op_r;
    stat.req_zero   = (wanted_r == '0);
    stat.addr_zero  = addr_zero_r;
    stat.init_ok    = (init_round != '0) && (init_round <= limit);
    stat.scan_end   = (idx_r >= count_r);
    stat.hit_alloc  = rd_r.free && (CW'(rd_r.size) >= wanted_c);
    stat.hit_free   = (AW'(rd_r.off) == tgt_r);
    stat.split      = split;
    stat.full       = (count_r >= NW'(ffha_pkg::MAX_BLOCKS));
    stat.grow_fit   = (new_end <= limit);
    stat.grow_room  = ((NW+1)'(count_r) + need) <= (NW+1)'(ffha_pkg::MAX_BLOCKS);
    stat.tbl_empty  = (count_r == '0);
    stat.idx_gt_pos = (idx_r > pos_r);
    stat.has_next   = ((NW+1)'(pos_r) + (NW+1)'(1)) < (NW+1)'(count_r);
    stat.fwd_ok     = rd_r.free && (CW'(rd_r.off) == cur_end);
    stat.shd_more   = (idx_r < count_r);
    stat.pos_zero   = (pos_r == '0);
    stat.bwd_ok     = rd_r.free && (CW'(cur_r.off) == rd_end);
    stat.cur_free   = cur_r.free;
  end

  // table write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_r;
    mem_wd = cur_r;
    case (cmd.code)
      ffha_pkg::C_SHU_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_r + NW'(1);
        mem_wd = rd_r;
      end
      ffha_pkg::C_SPLIT_INS: begin
        mem_we      = 1'b1;
        mem_wa      = pos_r + NW'(1);
        mem_wd.free = 1'b1;
        mem_wd.size = OB'(cur_sz - wanted_c - CW'(ffha_pkg::OVERHEAD));
        mem_wd.off  = OB'(CW'(cur_r.off) + wanted_c + CW'(ffha_pkg::OVERHEAD));
      end
      ffha_pkg::C_TAKE: begin
        mem_we      = 1'b1;
        mem_wd.free = 1'b0;
        mem_wd.size = final_sz;
      end
      ffha_pkg::C_FREE_MARK: begin
        mem_we      = 1'b1;
        mem_wd.free = 1'b1;
      end
      ffha_pkg::C_FWD_MERGE: begin
        mem_we      = 1'b1;
        mem_wd.free = 1'b1;
        mem_wd.size = OB'(cur_sz + CW'(rd_r.size) + CW'(ffha_pkg::OVERHEAD));
      end
      ffha_pkg::C_SHD_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_r - NW'(1);
        mem_wd = rd_r;
      end
      ffha_pkg::C_BWD_MERGE: begin
        mem_we      = 1'b1;
        mem_wa      = idx_r;
        mem_wd.free = 1'b1;
        mem_wd.off  = rd_r.off;
        mem_wd.size = OB'(CW'(rd_r.size) + cur_sz + CW'(ffha_pkg::OVERHEAD));
      end
      ffha_pkg::C_INIT: begin
        mem_we      = stat.init_ok;
        mem_wa      = '0;
        mem_wd.free = 1'b1;
        mem_wd.off  = '0;
        mem_wd.size = OB'(init_round - CW'(ffha_pkg::OVERHEAD));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa[ffha_pkg::IDX_W-1:0]] <= mem_wd;
    end
    if (cmd.code == ffha_pkg::C_RD) begin
      rd_r <= mem[idx_r[ffha_pkg::IDX_W-1:0]];
    end
  end

  // control-side counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      top_off_r    <= '0;
      live_cnt_r   <= '0;
      held_bytes_r <= '0;
    end else begin
      case (cmd.code)
        ffha_pkg::C_GROW: begin
          count_r   <= count_r + NW'(1);
          top_off_r <= BW'(new_end);
        end
        ffha_pkg::C_SPLIT_INS: count_r <= count_r + NW'(1);
        ffha_pkg::C_DEC_COUNT: count_r <= count_r - NW'(1);
        ffha_pkg::C_TAKE: begin
          live_cnt_r   <= live_cnt_r + NW'(1);
          held_bytes_r <= held_bytes_r + BW'(final_sz);
        end
        ffha_pkg::C_FREE_MARK: begin
          if (live_cnt_r != '0) begin
            live_cnt_r <= live_cnt_r - NW'(1);
          end
          held_bytes_r <= (held_bytes_r >= BW'(cur_r.size)) ?
                          held_bytes_r - BW'(cur_r.size) : '0;
        end
        ffha_pkg::C_INIT: begin
          count_r      <= stat.init_ok ? NW'(1) : '0;
          top_off_r    <= stat.init_ok ? BW'(init_round) : '0;
          live_cnt_r   <= '0;
          held_bytes_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // request payload, cursor and result registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      ffha_pkg::C_ACCEPT: begin
        op_r        <= in_op;
        wanted_r    <= wanted_in;
        tgt_r       <= in_free_address - cfg.region_base - AW'(ffha_pkg::HDR_BYTES);
        addr_zero_r <= (in_free_address == '0);
        idx_r       <= '0;
        res_addr_r  <= '0;
      end
      ffha_pkg::C_NEXT:     idx_r <= idx_r + NW'(1);
      ffha_pkg::C_HIT: begin
        cur_r <= rd_r;
        pos_r <= idx_r;
      end
      ffha_pkg::C_GROW: begin
        cur_r.free <= 1'b1;
        cur_r.off  <= OB'(top_off_r);
        cur_r.size <= OB'(grow - CW'(ffha_pkg::OVERHEAD));
        pos_r      <= count_r;
      end
      ffha_pkg::C_SHU_INIT: idx_r <= count_r - NW'(1);
      ffha_pkg::C_SHU_WR:   idx_r <= idx_r - NW'(1);
      ffha_pkg::C_TAKE: begin
        res_addr_r <= cfg.region_base + AW'(cur_r.off) + AW'(ffha_pkg::HDR_BYTES);
      end
      ffha_pkg::C_FREE_MARK: begin
        cur_r.free <= 1'b1;
        idx_r      <= pos_r + NW'(1);
      end
      ffha_pkg::C_FWD_MERGE: begin
        cur_r.size <= OB'(cur_sz + CW'(rd_r.size) + CW'(ffha_pkg::OVERHEAD));
        idx_r      <= pos_r + NW'(2);
      end
      ffha_pkg::C_SHD_WR:    idx_r <= idx_r + NW'(1);
      ffha_pkg::C_SET_PREV:  idx_r <= pos_r - NW'(1);
      ffha_pkg::C_BWD_MERGE: idx_r <= pos_r + NW'(1);
      ffha_pkg::C_EMIT: begin
        out_result_address <= res_addr_r;
        out_status         <= cmd.st;
        out_live_count     <= ffha_pkg::LIVE_W'(live_cnt_r);
        out_held_bytes     <= held_bytes_r;
        out_heap_bytes     <= top_off_r;
      end
      default: begin
      end
    endcase
  end

  `FFHA_NEVER(a_count_bound, clk, rst_n,
    count_r > NW'(ffha_pkg::MAX_BLOCKS), "descriptor count above table depth")
  `FFHA_NEVER(a_live_bound, clk, rst_n,
    live_cnt_r > NW'(ffha_pkg::MAX_BLOCKS), "live block count above table depth")
  `FFHA_ASSERT(a_take_clears, clk, rst_n,
    (cmd.code == ffha_pkg::C_TAKE) |=> (live_cnt_r != '0), "take left no live block")

endmodule

// ----- sv/ffha_ctrl.sv -----
// controller: sequences scan, split, growth and merge steps of one request
// depends on ffha_pkg and assert_macros.svh; commands ffha_dp
`include "assert_macros.svh"

module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISP      = 5'd1;
  localparam logic [4:0] S_SCAN_RD   = 5'd2;
  localparam logic [4:0] S_SCAN_CK   = 5'd3;
  localparam logic [4:0] S_ALLOC_HIT = 5'd4;
  localparam logic [4:0] S_GROW_CK   = 5'd5;
  localparam logic [4:0] S_SHU_RD    = 5'd6;
  localparam logic [4:0] S_SHU_WR    = 5'd7;
  localparam logic [4:0] S_SPLIT_INS = 5'd8;
  localparam logic [4:0] S_TAKE      = 5'd9;
  localparam logic [4:0] S_FREE_HIT  = 5'd10;
  localparam logic [4:0] S_FWD_RD    = 5'd11;
  localparam logic [4:0] S_FWD_CK    = 5'd12;
  localparam logic [4:0] S_SHD_RD    = 5'd13;
  localparam logic [4:0] S_SHD_WR    = 5'd14;
  localparam logic [4:0] S_BWD_SETUP = 5'd15;
  localparam logic [4:0] S_BWD_RD    = 5'd16;
  localparam logic [4:0] S_BWD_CK    = 5'd17;
  localparam logic [4:0] S_DONE      = 5'd18;

  logic [4:0]                state_r, state_nxt;
  logic [ffha_pkg::ST_W-1:0] st_r, st_nxt;
  logic                      bwd_r, bwd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      is_alloc;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign is_alloc  = (stat.op == ffha_pkg::OP_ALLOC);

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    bwd_nxt       = bwd_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.code      = ffha_pkg::C_NOP;
    cmd.st        = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.code  = ffha_pkg::C_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        st_nxt    = ffha_pkg::ST_OK;
        case (stat.op)
          ffha_pkg::OP_ALLOC: begin
            if (stat.req_zero) begin
              st_nxt = ffha_pkg::ST_NOOP;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          ffha_pkg::OP_FREE: begin
            if (stat.addr_zero) begin
              st_nxt = ffha_pkg::ST_NOOP;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          ffha_pkg::OP_INIT: begin
            cmd.code = ffha_pkg::C_INIT;
            st_nxt   = stat.init_ok ? ffha_pkg::ST_OK : ffha_pkg::ST_INIT_FAIL;
          end
          default: st_nxt = ffha_pkg::ST_OK;
        endcase
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          if (is_alloc) begin
            state_nxt = S_GROW_CK;
          end else begin
            st_nxt    = ffha_pkg::ST_BAD_PTR;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.code  = ffha_pkg::C_RD;
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (is_alloc ? stat.hit_alloc : stat.hit_free) begin
          cmd.code  = ffha_pkg::C_HIT;
          state_nxt = is_alloc ? S_ALLOC_HIT : S_FREE_HIT;
        end else begin
          cmd.code  = ffha_pkg::C_NEXT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_ALLOC_HIT: begin
        if (stat.split && stat.full) begin
          st_nxt    = ffha_pkg::ST_TBL_FULL;
          state_nxt = S_DONE;
        end else if (stat.split) begin
          cmd.code  = ffha_pkg::C_SHU_INIT;
          state_nxt = S_SHU_RD;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_GROW_CK: begin
        state_nxt = S_DONE;
        if (stat.tbl_empty || !stat.grow_fit) begin
          st_nxt = ffha_pkg::ST_NO_MEM;
        end else if (!stat.grow_room) begin
          st_nxt = ffha_pkg::ST_TBL_FULL;
        end else begin
          cmd.code  = ffha_pkg::C_GROW;
          state_nxt = S_ALLOC_HIT;
        end
      end
      S_SHU_RD: begin
        if (stat.idx_gt_pos) begin
          cmd.code  = ffha_pkg::C_RD;
          state_nxt = S_SHU_WR;
        end else begin
          state_nxt = S_SPLIT_INS;
        end
      end
      S_SHU_WR: begin
        cmd.code  = ffha_pkg::C_SHU_WR;
        state_nxt = S_SHU_RD;
      end
      S_SPLIT_INS: begin
        cmd.code  = ffha_pkg::C_SPLIT_INS;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.code  = ffha_pkg::C_TAKE;
        st_nxt    = ffha_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_FREE_HIT: begin
        if (stat.cur_free) begin
          st_nxt    = ffha_pkg::ST_DBL_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.code  = ffha_pkg::C_FREE_MARK;
          state_nxt = stat.has_next ? S_FWD_RD : S_BWD_SETUP;
        end
      end
      S_FWD_RD: begin
        cmd.code  = ffha_pkg::C_RD;
        state_nxt = S_FWD_CK;
      end
      S_FWD_CK: begin
        if (stat.fwd_ok) begin
          cmd.code  = ffha_pkg::C_FWD_MERGE;
          bwd_nxt   = 1'b0;
          state_nxt = S_SHD_RD;
        end else begin
          state_nxt = S_BWD_SETUP;
        end
      end
      S_SHD_RD: begin
        if (stat.shd_more) begin
          cmd.code  = ffha_pkg::C_RD;
          state_nxt = S_SHD_WR;
        end else begin
          cmd.code = ffha_pkg::C_DEC_COUNT;
          if (bwd_r) begin
            st_nxt    = ffha_pkg::ST_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_BWD_SETUP;
          end
        end
      end
      S_SHD_WR: begin
        cmd.code  = ffha_pkg::C_SHD_WR;
        state_nxt = S_SHD_RD;
      end
      S_BWD_SETUP: begin
        if (stat.pos_zero) begin
          st_nxt    = ffha_pkg::ST_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.code  = ffha_pkg::C_SET_PREV;
          state_nxt = S_BWD_RD;
        end
      end
      S_BWD_RD: begin
        cmd.code  = ffha_pkg::C_RD;
        state_nxt = S_BWD_CK;
      end
      S_BWD_CK: begin
        if (stat.bwd_ok) begin
          cmd.code  = ffha_pkg::C_BWD_MERGE;
          bwd_nxt   = 1'b1;
          state_nxt = S_SHD_RD;
        end else begin
          st_nxt    = ffha_pkg::ST_OK;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.code      = ffha_pkg::C_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= ffha_pkg::ST_OK;
      bwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      bwd_r       <= bwd_nxt;
    end
  end

  `FFHA_ASSERT(a_accept_dispatch, clk, rst_n,
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DISP), "accepted request not dispatched")
  `FFHA_ASSERT(a_emit_from_done, clk, rst_n,
    (state_r == S_DONE && (!out_valid_r || !out_stall)) |=> (out_valid_r && state_r == S_IDLE),
    "result not presented on completion")
  `FFHA_ASSERT(a_only_done_emits, clk, rst_n,
    (cmd.code == ffha_pkg::C_EMIT) |-> (state_r == S_DONE), "emit outside done state")

endmodule

// ----- sv/first_fit_heap_allocator_top.sv -----
// top level of the first-fit heap allocator: apb register file and the two halves
// depends on ffha_pkg, ffha_ctrl and ffha_dp
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_stall   op, request_bytes, free_address
//   out_      result     out_valid / out_stall result_address, status, live_count,
//                                              held_bytes, heap_bytes
//   apb       config     psel/penable/pready   paddr, pwdata, prdata
//
// one request at a time; the descriptor table is a single-port memory walked one
// entry per read/write pair (scan, then insert or remove shifts)
// reset clears counts and heap size; table contents are undefined until init
// a finished result waits in the output register while the next request is taken
module first_fit_heap_allocator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ffha_pkg::OP_W-1:0]    in_op,
  input  logic [ffha_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]  in_free_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]  out_result_address,
  output logic [ffha_pkg::ST_W-1:0]    out_status,
  output logic [ffha_pkg::LIVE_W-1:0]  out_live_count,
  output logic [ffha_pkg::BYTES_W-1:0] out_held_bytes,
  output logic [ffha_pkg::BYTES_W-1:0] out_heap_bytes,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // register word indexes
  localparam logic [1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [1:0] REG_INITIAL   = 2'd1;
  localparam logic [1:0] REG_MAX       = 2'd2;

  ffha_pkg::cfg_t     cfg_r;
  ffha_pkg::cmd_t     cmd;
  ffha_pkg::dp_stat_t stat;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // config writes land in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_base   <= '0;
      cfg_r.initial_bytes <= ffha_pkg::BYTES_W'(65536);
      cfg_r.max_bytes     <= ffha_pkg::BYTES_W'(16777216);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HEAP_BASE: cfg_r.region_base   <= pwdata;
        REG_INITIAL:   cfg_r.initial_bytes <= pwdata[ffha_pkg::BYTES_W-1:0];
        REG_MAX:       cfg_r.max_bytes     <= pwdata[ffha_pkg::BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read mux, zero-extended
  always_comb begin
    unique case (paddr[3:2])
      REG_HEAP_BASE: prdata = cfg_r.region_base;
      REG_INITIAL:   prdata = 32'(cfg_r.initial_bytes);
      REG_MAX:       prdata = 32'(cfg_r.max_bytes);
      default:       prdata = '0;
    endcase
  end

  // sequencer for scan / split / merge steps
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // descriptor table and heap arithmetic
  ffha_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_op              (in_op),
    .in_request_bytes   (in_request_bytes),
    .in_free_address    (in_free_address),
    .stat               (stat),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .out_live_count     (out_live_count),
    .out_held_bytes     (out_held_bytes),
    .out_heap_bytes     (out_heap_bytes)
  );

endmodule
